@@ hdl/easing_curve_interpolator_unit_defines.svh @@
// Assertion macros for the easing curve interpolator checker.
`ifndef EASING_CURVE_INTERPOLATOR_UNIT_DEFINES_SVH
`define EASING_CURVE_INTERPOLATOR_UNIT_DEFINES_SVH

// Overlapping implication, clocked on clk, off during reset.
`define ECI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication, clocked on clk, off during reset.
`define ECI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/eci_pkg.sv @@
// Package for the easing curve interpolator: defaults, latencies and curve codes.
package eci_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int VALUE_BITS_DEF = 24;
  localparam int FUNC_BITS      = 3;
  localparam int FACTOR_LATENCY = 3;
  localparam int PIPE_LATENCY   = FACTOR_LATENCY + 2;

  typedef enum logic [FUNC_BITS-1:0] {
    CURVE_LINEAR       = 3'd0,
    CURVE_IN_QUAD      = 3'd1,
    CURVE_OUT_QUAD     = 3'd2,
    CURVE_IN_OUT_QUAD  = 3'd3,
    CURVE_IN_CUBIC     = 3'd4,
    CURVE_OUT_CUBIC    = 3'd5,
    CURVE_IN_OUT_CUBIC = 3'd6,
    CURVE_LINEAR_ALT   = 3'd7
  } curve_t;

endpackage

@@ hdl/eci_factor.sv @@
// Three-stage pipeline computing the easing factor f(t) in unsigned Q1.FRAC_BITS.
module eci_factor import eci_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [FUNC_BITS-1:0] func,
  input  logic [FRAC_BITS:0]   progress,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   factor
);

  localparam int F = FRAC_BITS;
  localparam logic [F:0]   ONE  = {1'b1, {F{1'b0}}};
  localparam logic [F:0]   HALF = ONE >> 1;
  localparam logic [F+2:0] ONE_W  = {2'b00, ONE};
  localparam logic [F+2:0] TWO_W  = {1'b0, ONE, 1'b0};
  localparam logic [F+2:0] FOUR_W = {ONE, 2'b00};

  // stage 1: clamp, half split, base operand
  curve_t     sel_c;
  logic [F:0] t_c;
  logic [F:0] u_c;
  logic [F:0] x_c;
  logic       lo_c;

  logic       v1;
  curve_t     sel1;
  logic [F:0] t1;
  logic [F:0] x1;
  logic       lo1;

  always_comb begin
    sel_c = curve_t'(func);
    t_c   = (progress > ONE) ? ONE : progress;
    lo_c  = (t_c < HALF);
    u_c   = ONE - t_c;
    x_c   = ((sel_c == CURVE_OUT_CUBIC) || ((sel_c == CURVE_IN_OUT_CUBIC) && !lo_c)) ?
            u_c : t_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    sel1 <= sel_c;
    t1   <= t_c;
    x1   <= x_c;
    lo1  <= lo_c;
  end

  // stage 2: square or quadratic product
  logic [F+2:0]   b_c;
  logic [F+2:0]   two_t;
  logic [2*F+3:0] prod2;
  logic [F+3:0]   pq;

  logic       v2;
  curve_t     sel2;
  logic [F:0] t2;
  logic [F:0] x2;
  logic [F:0] p2;
  logic       lo2;

  always_comb begin
    two_t = {1'b0, t1, 1'b0};
    unique case (sel1)
      CURVE_OUT_QUAD:    b_c = TWO_W - {2'b00, t1};
      CURVE_IN_OUT_QUAD: b_c = lo1 ? two_t : (FOUR_W - two_t);
      default:           b_c = {2'b00, x1};
    endcase
    prod2 = {{(F+3){1'b0}}, x1} * {{(F+1){1'b0}}, b_c};
    pq    = prod2[2*F+3:F];
    if ((sel1 == CURVE_IN_OUT_QUAD) && !lo1) begin
      pq = pq - {3'b000, ONE};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    sel2 <= sel1;
    t2   <= t1;
    x2   <= x1;
    lo2  <= lo1;
    p2   <= pq[F:0];
  end

  // stage 3: cube and final factor
  logic [2*F+1:0] prod3;
  logic [F+2:0]   cw;
  logic [F+2:0]   c4;
  logic [F+2:0]   fw;

  always_comb begin
    prod3 = {{(F+1){1'b0}}, p2} * {{(F+1){1'b0}}, x2};
    cw    = {1'b0, prod3[2*F+1:F]};
    c4    = {prod3[2*F:F], 2'b00};
    unique case (sel2)
      CURVE_IN_QUAD, CURVE_OUT_QUAD, CURVE_IN_OUT_QUAD: fw = {2'b00, p2};
      CURVE_IN_CUBIC:                                   fw = cw;
      CURVE_OUT_CUBIC:                                  fw = ONE_W - cw;
      CURVE_IN_OUT_CUBIC:                               fw = lo2 ? c4 : (ONE_W - c4);
      CURVE_LINEAR, CURVE_LINEAR_ALT:                   fw = {2'b00, t2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    factor <= (fw > ONE_W) ? ONE : fw[F:0];
  end

endmodule

@@ hdl/easing_curve_interpolator_unit.sv @@
// Top level of the easing curve interpolator: factor pipeline, scale and offset.
//
//  channel   | ports                                           | handshake
//  ----------+-------------------------------------------------+--------------------
//  request   | func, progress, start_value, end_value          | start && !busy
//  result    | eased_value                                     | done, one cycle
//
// From the accepting edge the result passes through these registered stages:
// three factor stages (clamp, square, cube), one scaling multiply, one offset add.
// A new transaction may be accepted every cycle; busy is high only in the cycle
// after a reset cycle. Reset is synchronous and clears the valid chain, so
// transactions in flight are dropped. The receiver cannot stall the pipeline.
module easing_curve_interpolator_unit import eci_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [FUNC_BITS-1:0]         func,
  input  logic [FRAC_BITS:0]           progress,
  input  logic signed [VALUE_BITS-1:0] start_value,
  input  logic signed [VALUE_BITS-1:0] end_value,
  output logic                         done,
  output logic signed [VALUE_BITS-1:0] eased_value
);

  localparam int F      = FRAC_BITS;
  localparam int VB     = VALUE_BITS;
  localparam int PROD_W = VB + F + 3;
  localparam int SUM_W  = PROD_W - F;

  logic accept;
  logic f_valid;
  logic [F:0] f_val;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  eci_factor #(
    .FRAC_BITS(FRAC_BITS)
  ) u_factor (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .func     (func),
    .progress (progress),
    .out_valid(f_valid),
    .factor   (f_val)
  );

  // difference and start travel beside the factor pipeline
  logic signed [VB:0]   diff_c;
  logic signed [VB:0]   diff_d  [FACTOR_LATENCY];
  logic signed [VB-1:0] start_d [FACTOR_LATENCY];

  assign diff_c = {end_value[VB-1], end_value} - {start_value[VB-1], start_value};

  always_ff @(posedge clk) begin
    diff_d[0]  <= diff_c;
    start_d[0] <= start_value;
    for (int i = 1; i < FACTOR_LATENCY; i++) begin
      diff_d[i]  <= diff_d[i-1];
      start_d[i] <= start_d[i-1];
    end
  end

  // scale stage
  logic                     v4;
  logic signed [PROD_W-1:0] prod;
  logic signed [VB-1:0]     start4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    prod   <= PROD_W'(diff_d[FACTOR_LATENCY-1] * $signed({1'b0, f_val}));
    start4 <= start_d[FACTOR_LATENCY-1];
  end

  // offset stage, floor by arithmetic shift
  logic signed [SUM_W-1:0] sum_c;

  assign sum_c = {{(SUM_W-VB){start4[VB-1]}}, start4} + $signed(prod[PROD_W-1:F]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    eased_value <= sum_c[VB-1:0];
  end

endmodule

@@ hdl/eci_checker.sv @@
// Port-level checker for the easing curve interpolator, bound to the top level.
`include "easing_curve_interpolator_unit_defines.svh"

module eci_checker import eci_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic [FRAC_BITS:0]           progress,
  input logic signed [VALUE_BITS-1:0] start_value,
  input logic signed [VALUE_BITS-1:0] end_value,
  input logic                         done,
  input logic signed [VALUE_BITS-1:0] eased_value
);

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  `ECI_ASSERT_IMP(a_result_follows, start && !busy, ##PIPE_LATENCY done,
    "accepted transaction gave no result")

  `ECI_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, PIPE_LATENCY),
    "result without an accepted transaction")

  `ECI_ASSERT_IMP(a_flat_span, start && !busy && (start_value == end_value),
    ##PIPE_LATENCY (eased_value == $past(start_value, PIPE_LATENCY)),
    "equal endpoints did not give the start value")

  `ECI_ASSERT_IMP(a_full_progress, start && !busy && (progress >= ONE),
    ##PIPE_LATENCY (eased_value == $past(end_value, PIPE_LATENCY)),
    "full progress did not give the end value")

endmodule

bind easing_curve_interpolator_unit eci_checker #(
  .FRAC_BITS (FRAC_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_eci_checker (.*);
